FILE: rtl/mat_pkg.sv
// ============================================================================
// mat_pkg - multicast address table shared definitions
// Opcodes, controller states and the command/status bundles between the
// controller and the datapath.
// ============================================================================
package mat_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int ADDR_W              = 48;
    localparam int OP_W                = 2;
    localparam int COUNT_OUT_W         = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic add;     // append input address if room, result ok = room
        logic load;    // latch op/address, rewind scan pointers
        logic scan;    // walk one entry per cycle
        logic finish;  // commit scan result and new count
        logic fail;    // result ok = 0, table untouched
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

FILE: rtl/mat_ctrl.sv
// ============================================================================
// mat_ctrl - multicast address table controller
// Sequences add, delete and find words and holds the result until taken.
// ============================================================================
module mat_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [mat_pkg::OP_W-1:0] op,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output mat_pkg::dp_cmd_t       cmd,
    input  mat_pkg::dp_stat_t      stat
);
    import mat_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (op)
                        OP_ADD: begin
                            cmd.add    = 1'b1;
                            state_next = ST_RESULT;
                        end
                        OP_DELETE, OP_FIND: begin
                            cmd.load   = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            cmd.fail   = 1'b1;
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mat_datapath.sv
// ============================================================================
// mat_datapath - multicast address table storage and scan datapath
// Entry memory, count, scan read/write pointers, compare and result flag.
// ============================================================================
module mat_datapath #(
    parameter int TABLE_DEPTH = mat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mat_pkg::OP_W-1:0]      op,
    input  logic [mat_pkg::ADDR_W-1:0]    mac_address,
    input  mat_pkg::dp_cmd_t              cmd,
    output mat_pkg::dp_stat_t             stat,
    output logic                          ok,
    output logic [mat_pkg::COUNT_OUT_W-1:0] entry_count
);
    import mat_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [ADDR_W-1:0] mem [TABLE_DEPTH];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  wr_ptr_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              is_delete_reg;
    logic              hit_reg;
    logic              ok_reg;

    logic              full;
    logic              issue;
    logic              match;
    logic              keep_wr;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign full    = (count_reg == DEPTH_CNT);
    assign issue   = cmd.scan && (rd_ptr_reg != count_reg);
    assign match   = (rd_data_reg == addr_reg);
    // surviving entry during delete moves down to the write pointer
    assign keep_wr = cmd.scan && rd_vld_reg && !match && is_delete_reg;

    assign stat.scan_done = (rd_ptr_reg == count_reg) && !rd_vld_reg;

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.add && !full) begin
            mem[count_reg[IDX_W-1:0]] <= mac_address;
        end else if (keep_wr) begin
            mem[wr_ptr_reg[IDX_W-1:0]] <= rd_data_reg;
        end
        if (issue) begin
            rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
                rd_vld_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end else if (cmd.scan) begin
                rd_vld_reg <= issue;
                if (issue) begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                if (rd_vld_reg && match) begin
                    hit_reg <= 1'b1;
                end
                if (keep_wr) begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (cmd.add && !full) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.finish && is_delete_reg) begin
                count_reg <= wr_ptr_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg      <= mac_address;
            is_delete_reg <= (op == OP_DELETE);
        end
        priority if (cmd.add) begin
            ok_reg <= !full;
        end else if (cmd.fail) begin
            ok_reg <= 1'b0;
        end else if (cmd.finish) begin
            ok_reg <= hit_reg;
        end
    end

    assign count_ext   = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign entry_count = count_ext[COUNT_OUT_W-1:0];
    assign ok          = ok_reg;

endmodule

FILE: rtl/multicast_address_table.sv
// ============================================================================
// multicast_address_table - ordered table of Ethernet multicast addresses
// Add, delete-all-copies and find on up to TABLE_DEPTH 48-bit addresses.
// ============================================================================
// Usage:
//   Input channel s_*: one word per operation. s_tuser carries the opcode
//   (add, delete all copies, find), s_tdata the 48-bit address.
//   Output channel m_*: exactly one word per input word, in order, with the
//   ok flag and the entry count after the operation.
//   Add appends at the end of the list; a full table rejects it (ok = 0).
//   Delete removes every match and compacts the rest in order. Find reports
//   whether the address is held. Unused opcode: no change, ok = 0.
// Timing:
//   One word at a time. Add and unused opcodes load the result register at
//   the accepting edge, so the result is offered in the next cycle. Delete
//   and find walk the entry memory one entry per cycle through its
//   registered read port. s_tready returns in the cycle after the result
//   is taken.
// Reset / stall:
//   aresetn (synchronous, active low) empties the table; no clearing pass
//   since only entries below the count are read. A stalled m_tready holds
//   the result and s_tready stays low until it is taken.
// ============================================================================
module multicast_address_table #(
    parameter int TABLE_DEPTH = mat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] mac_address
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] ok, [5:1] entry_count, [7:6] zero
);
    import mat_pkg::*;

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic                   res_ok;
    logic [COUNT_OUT_W-1:0] res_count;

    mat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (s_tuser),
        .mac_address (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .ok          (res_ok),
        .entry_count (res_count)
    );

    // result word, zero padded to a byte
    assign m_tdata = {2'b00, res_count, res_ok};

endmodule

FILE: bench/mat_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat_result_checker - table predictor and result comparator
// Watches both stream channels, keeps a shadow copy of the address list,
// queues the status expected for every accepted input word and checks each
// result word against the oldest one.
// ----------------------------------------------------------------------------
module mat_result_checker #(
    parameter int TABLE_DEPTH = mat_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [mat_pkg::ADDR_W-1:0] s_tdata,   // [47:0] mac_address
    input  logic [mat_pkg::OP_W-1:0]   s_tuser,   // [1:0] opcode
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [7:0]                 m_tdata,   // [0] ok, [5:1] entry_count, [7:6] zero
    output int                         fail_count,
    output int                         pending,
    output int                         results_seen,
    output int                         full_rejects,
    output int                         delete_hits,
    output int                         find_hits
);
    import mat_pkg::*;

    typedef struct packed {
        logic                   ok;
        logic [COUNT_OUT_W-1:0] entry_count;
    } table_status_t;

    logic [ADDR_W-1:0] shadow_addr [TABLE_DEPTH];
    int                shadow_count;
    table_status_t     expected_status_q [$];

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        full_rejects = 0;
        delete_hits  = 0;
        find_hits    = 0;
        shadow_count = 0;
    end

    // Apply one operation to the shadow table and return the status it yields.
    function automatic table_status_t apply_table_op(input logic [OP_W-1:0]   op,
                                                     input logic [ADDR_W-1:0] addr);
        table_status_t st;
        logic          hit;
        int            wr;
        hit = 1'b0;
        wr  = 0;
        case (op)
            OP_ADD: begin
                if (shadow_count < TABLE_DEPTH) begin
                    shadow_addr[shadow_count] = addr;
                    shadow_count++;
                    hit = 1'b1;
                end else begin
                    full_rejects++;
                end
            end
            OP_DELETE: begin
                // remove every copy, compact the survivors in order
                for (int rd = 0; rd < shadow_count; rd++) begin
                    if (shadow_addr[rd] == addr) begin
                        hit = 1'b1;
                    end else begin
                        shadow_addr[wr] = shadow_addr[rd];
                        wr++;
                    end
                end
                shadow_count = wr;
                if (hit) delete_hits++;
            end
            OP_FIND: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_addr[i] == addr) hit = 1'b1;
                end
                if (hit) find_hits++;
            end
            default: ;  // unused opcode: no change
        endcase
        st.ok          = hit;
        st.entry_count = COUNT_OUT_W'(shadow_count);
        return st;
    endfunction

    always @(posedge aclk) begin
        table_status_t want;
        if (!aresetn) begin
            shadow_count = 0;
            expected_status_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_status_q.push_back(apply_table_op(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_status_q.size() == 0) begin
                    $error("result word 0x%02h with no expectation waiting", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (m_tdata[0] !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[5:1] !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, m_tdata[5:1]);
                        fail_count++;
                    end
                    if (m_tdata[7:6] !== 2'b00) begin
                        $error("padding: expected 0, actual %0d", m_tdata[7:6]);
                        fail_count++;
                    end
                end
            end
        end
        pending = expected_status_q.size();
    end

endmodule

FILE: bench/tb_multicast_address_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multicast_address_table - stimulus and verdict for the address table
// Drives a directed opener (empty table, extremes, duplicates, full table,
// unused opcode), then segments that alternately grow and shrink the table
// from a small address pool so deletes and finds hit. Both channels idle in
// random bursts, with one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_multicast_address_table;
    import mat_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;   // no meaning, must be ignored

    localparam int POOL_SIZE    = 12;    // small pool keeps hit rate high
    localparam int RANDOM_WORDS = 1025;
    localparam int QUIET_WORDS  = 175;   // tail of the run with no idling
    localparam int SEGMENT_LEN  = 40;    // words per grow / shrink segment
    localparam int LONG_HOLD    = 400;   // cycles of the long output stall
    localparam int HOLD_AT_WORD = 300;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ADDR_W-1:0] s_tdata  = '0;     // [47:0] mac_address
    logic [OP_W-1:0]   s_tuser  = '0;     // [1:0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;           // [0] ok, [5:1] entry_count, [7:6] zero

    int fail_count, pending, results_seen, full_rejects, delete_hits, find_hits;

    bit idle_on     = 1'b1;   // random gaps on both sides
    bit hold_req    = 1'b0;   // ask the receiver for one long stall
    int held_cycles = 0;
    int words_sent  = 0;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    multicast_address_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    mat_result_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen),
        .full_rejects(full_rejects),
        .delete_hits (delete_hits),
        .find_hits   (find_hits)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Safety net: the slowest legal run ends well before this timeout.
    initial begin
        #3_000_000;
        $display("multicast_address_table test failed");
        $finish;
    end

    // Receiver: one decision per step, so m_tready gets one NBA per edge.
    initial begin
        forever begin
            if (hold_req) begin
                // long stall: block finishes its word, then s_tready drops
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) begin
                    @(posedge aclk);
                    held_cycles++;
                end
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Full-width random address; every bit toggles over the run.
    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    // Offer one word and return at the edge that accepts it. Called at a
    // rising edge; valid stays high across back-to-back words.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    initial begin
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        int                pick;
        bit                growing;

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) begin
            addr_pool[i] = rand_addr() | (48'h1 << 40);   // group bit set
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed opener ---
        send_word(OP_FIND,   addr_pool[2]);     // find on empty table
        send_word(OP_DELETE, addr_pool[2]);     // delete on empty table
        send_word(OP_ADD,    addr_pool[0]);     // all-zero address
        send_word(OP_ADD,    addr_pool[1]);     // all-ones address
        send_word(OP_ADD,    addr_pool[2]);
        send_word(OP_ADD,    addr_pool[2]);     // duplicate kept
        for (int i = 0; i < TABLE_DEPTH - 4; i++) begin
            send_word(OP_ADD, addr_pool[3 + i % (POOL_SIZE - 3)]);
        end
        send_word(OP_ADD,    rand_addr());      // table full: rejected
        send_word(OP_FIND,   addr_pool[2]);     // hit in full table
        send_word(OP_FIND,   rand_addr());      // miss
        send_word(OP_UNUSED, addr_pool[2]);     // ignored
        send_word(OP_DELETE, addr_pool[2]);     // both copies go, rest compacts
        send_word(OP_DELETE, addr_pool[2]);     // already gone
        send_word(OP_DELETE, addr_pool[1]);

        // --- random segments, alternately filling and draining ---
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            growing = ((n / SEGMENT_LEN) % 2) == 0;
            pick = $urandom_range(0, 99);
            if (growing) begin
                op = (pick < 60) ? OP_ADD : (pick < 75) ? OP_DELETE :
                     (pick < 95) ? OP_FIND : OP_UNUSED;
            end else begin
                op = (pick < 25) ? OP_ADD : (pick < 65) ? OP_DELETE :
                     (pick < 95) ? OP_FIND : OP_UNUSED;
            end
            addr = ($urandom_range(0, 4) != 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : rand_addr();
            if (n == HOLD_AT_WORD) hold_req = 1'b1;
            if (n == RANDOM_WORDS - QUIET_WORDS) idle_on = 1'b0;
            send_word(op, addr);
        end
        s_tvalid <= 1'b0;

        // drain: wait until every expectation is met, then idle to catch stray words
        do @(posedge aclk); while (pending != 0);
        repeat (TABLE_DEPTH + 8) @(posedge aclk);

        $display("%0d words sent, %0d results checked, %0d output stall cycles",
                 words_sent, results_seen, held_cycles);
        $display("full-table rejects %0d, delete hits %0d, find hits %0d",
                 full_rejects, delete_hits, find_hits);
        if (fail_count == 0) begin
            $display("multicast_address_table test passed");
        end else begin
            $display("multicast_address_table test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/mat_pkg.sv
rtl/mat_ctrl.sv
rtl/mat_datapath.sv
rtl/multicast_address_table.sv
bench/mat_result_checker.sv
bench/tb_multicast_address_table.sv
